>>> sv/rtcv_pkg.sv
// shared types and constants for the reservation table collision vector block
// no dependencies; imported by rtcv_scan and reservation_table_collision_vector
package rtcv_pkg;

	localparam int SPAN_W     = 7;
	localparam int ROW_IDX_W  = 3;
	localparam int ROW_BITS_W = 32;
	localparam int ROWCNT_W   = 4;
	localparam int COLCNT_W   = 6;
	localparam int MASK_W     = 64;
	localparam int VERDICT_W  = 2;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = 1;

	// item kinds
	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_LATENCY = 1'b1;

	// result verdicts
	localparam logic [VERDICT_W-1:0] VERDICT_ANALYSED  = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_ACCEPTED  = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_FORBIDDEN = 2'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_OVER_SPAN = 2'd3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

	typedef struct packed {
		logic start;
		logic collect;
		logic clear;
	} scan_ctrl_t;

	// ones in bits below n, all ones for n of 64 or more
	function automatic logic [MASK_W-1:0] low_ones(input logic [SPAN_W-1:0] n);
		logic [MASK_W-1:0] m;
		for (int i = 0; i < MASK_W; i++) begin
			m[i] = (i < int'(n));
		end
		return m;
	endfunction

endpackage

>>> sv/rtcv_scan.sv
// distance scanner: walks column distances one per cycle over all table rows,
// collects forbidden latencies and tracks the greatest permissible one
// depends on rtcv_pkg
module rtcv_scan #(
	parameter int ROWS  = 8,
	parameter int WIDTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rtcv_pkg::scan_ctrl_t        ctrl,
	input  logic [WIDTH-1:0]            rows_in [ROWS],
	input  logic [ROWS-1:0]             row_en,
	input  logic [rtcv_pkg::SPAN_W-1:0] span,
	output logic                        done,
	output logic [WIDTH-1:0]            forbidden,
	output logic [rtcv_pkg::SPAN_W-1:0] length
);
	import rtcv_pkg::*;

	localparam int DW  = $clog2(WIDTH + 1);
	localparam int FIW = $clog2(WIDTH);

	logic [WIDTH-1:0]  sh_q [ROWS];
	logic [DW-1:0]     d_q;
	logic              busy_q;
	logic              collect_q;
	logic              done_q;
	logic [WIDTH-1:0]  forb_q;
	logic [SPAN_W-1:0] len_q;

	logic              hit;
	logic [FIW-1:0]    bit_idx;
	logic              fbit;

	// a row of the table and its copy shifted by the current distance overlap
	always_comb begin
		hit = 1'b0;
		for (int r = 0; r < ROWS; r++) begin
			if (row_en[r]) begin
				hit = hit | (|(rows_in[r] & sh_q[r]));
			end
		end
		hit = hit & collect_q;
	end

	assign bit_idx = FIW'(d_q - DW'(1));
	assign fbit    = forb_q[bit_idx] | hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			collect_q <= 1'b0;
			d_q       <= '0;
			forb_q    <= '0;
			len_q     <= '0;
			for (int r = 0; r < ROWS; r++) begin
				sh_q[r] <= '0;
			end
		end else begin
			done_q <= !ctrl.start && busy_q && (d_q == DW'(WIDTH));
			if (ctrl.clear) begin
				forb_q <= '0;
			end
			if (ctrl.start) begin
				busy_q    <= 1'b1;
				collect_q <= ctrl.collect;
				d_q       <= DW'(1);
				len_q     <= '0;
				for (int r = 0; r < ROWS; r++) begin
					sh_q[r] <= rows_in[r] >> 1;
				end
			end else if (busy_q) begin
				forb_q[bit_idx] <= fbit;
				if ((int'(d_q) <= int'(span)) && !fbit) begin
					len_q <= SPAN_W'(d_q);
				end
				for (int r = 0; r < ROWS; r++) begin
					sh_q[r] <= sh_q[r] >> 1;
				end
				if (d_q == DW'(WIDTH)) begin
					busy_q <= 1'b0;
				end else begin
					d_q <= d_q + DW'(1);
				end
			end
		end
	end

	assign done      = done_q;
	assign forbidden = forb_q;
	assign length    = len_q;

endmodule

>>> sv/reservation_table_collision_vector.sv
// top level: configuration registers, table storage, merge sequencer and result register
// depends on rtcv_pkg and rtcv_scan
//
// Load table rows with kind 0, then propose latencies with kind 1; one item is taken at a
// time. A load of a row other than the last gives no result. The last row and every
// latency run the distance scan, which checks one column distance per cycle over the
// used rows before the result is registered; an accepted latency first merges the shifted
// original table one row per cycle through a single shifter. A new item is taken only once
// the previous result has been taken. Write row_count and column_count while the block is
// idle.
module reservation_table_collision_vector #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 32,
	parameter int MAX_SPAN = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rtcv_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rtcv_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rtcv_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic                            kind,
	input  logic [rtcv_pkg::ROW_IDX_W-1:0]  row_index,
	input  logic [rtcv_pkg::ROW_BITS_W-1:0] row_bits,
	input  logic [rtcv_pkg::SPAN_W-1:0]     latency,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [rtcv_pkg::VERDICT_W-1:0]  verdict,
	output logic [rtcv_pkg::MASK_W-1:0]     forbidden_mask,
	output logic [rtcv_pkg::MASK_W-1:0]     permissible_mask,
	output logic [rtcv_pkg::SPAN_W-1:0]     span,
	output logic [rtcv_pkg::MASK_W-1:0]     collision_vector,
	output logic [rtcv_pkg::SPAN_W-1:0]     vector_length
);
	import rtcv_pkg::*;

	localparam int OW = (MAX_COLS < ROW_BITS_W) ? MAX_COLS : ROW_BITS_W;
	localparam int MW = (MAX_COLS > MAX_SPAN) ? MAX_COLS : MAX_SPAN;
	localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RW = $clog2(MAX_ROWS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MERGE,
		ST_KICK,
		ST_SCAN
	} state_t;

	state_t                 state_q;
	logic [ROWCNT_W-1:0]    row_count_q;
	logic [COLCNT_W-1:0]    column_count_q;
	logic [OW-1:0]          orig_q [MAX_ROWS];
	logic [MW-1:0]          merged_q [MAX_ROWS];
	logic [SPAN_W-1:0]      span_q;
	logic [SPAN_W-1:0]      lat_q;
	logic [IW-1:0]          rc_q;
	logic                   collect_q;
	logic [VERDICT_W-1:0]   verdict_sel_q;

	logic                   out_valid_q;
	logic [VERDICT_W-1:0]   verdict_q;
	logic [MASK_W-1:0]      forbidden_mask_q;
	logic [MASK_W-1:0]      permissible_mask_q;
	logic [SPAN_W-1:0]      span_out_q;
	logic [MASK_W-1:0]      collision_vector_q;
	logic [SPAN_W-1:0]      vector_length_q;

	logic                   cfg_write;
	logic [REG_IDX_W-1:0]   reg_idx;
	logic [RW-1:0]          rows_eff;
	logic [SPAN_W-1:0]      cols_eff;
	logic                   item_accept;
	logic                   row_in_range;
	logic                   row_last;
	logic [IW-1:0]          row_sel;
	logic [OW-1:0]          omask;
	logic [OW-1:0]          load_bits;
	logic [MW-1:0]          merge_row;
	logic                   merge_last;
	logic [MASK_W-1:0]      forb64;
	logic                   lat_forbidden;
	logic                   lat_over;
	logic [MAX_ROWS-1:0]    row_en;

	scan_ctrl_t             scan_ctrl;
	logic                   scan_done;
	logic [MW-1:0]          scan_forb;
	logic [SPAN_W-1:0]      scan_len;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_idx   = paddr[2];

	always_comb begin
		unique case (reg_idx)
			REG_ROW_COUNT:    prdata = APB_DATA_W'(row_count_q);
			REG_COLUMN_COUNT: prdata = APB_DATA_W'(column_count_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= ROWCNT_W'(1);
			column_count_q <= COLCNT_W'(1);
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_ROW_COUNT:    row_count_q    <= pwdata[ROWCNT_W-1:0];
				REG_COLUMN_COUNT: column_count_q <= pwdata[COLCNT_W-1:0];
			endcase
		end
	end

	// clamped row and column counts
	always_comb begin
		if (row_count_q == '0) begin
			rows_eff = RW'(1);
		end else if (int'(row_count_q) > MAX_ROWS) begin
			rows_eff = RW'(MAX_ROWS);
		end else begin
			rows_eff = RW'(row_count_q);
		end
		if (column_count_q == '0) begin
			cols_eff = SPAN_W'(1);
		end else if (int'(column_count_q) > MAX_COLS) begin
			cols_eff = SPAN_W'(MAX_COLS);
		end else begin
			cols_eff = SPAN_W'(column_count_q);
		end
	end

	always_comb begin
		for (int r = 0; r < MAX_ROWS; r++) begin
			row_en[r] = (r < int'(rows_eff));
		end
	end

	assign item_ready   = (state_q == ST_IDLE) && !out_valid_q;
	assign item_accept  = item_valid && item_ready;
	assign row_in_range = int'(row_index) < int'(rows_eff);
	assign row_last     = int'(row_index) == int'(rows_eff) - 1;
	assign row_sel      = IW'(row_index);
	assign omask        = OW'(low_ones(cols_eff));
	assign load_bits    = OW'(row_bits) & omask;
	assign merge_row    = MW'(orig_q[rc_q] & omask) << lat_q;
	assign merge_last   = int'(rc_q) == int'(rows_eff) - 1;

	assign forb64        = MASK_W'(scan_forb);
	assign lat_forbidden = (latency != '0) && (int'(latency) <= MASK_W)
		&& forb64[6'(latency - SPAN_W'(1))];
	assign lat_over      = (int'(latency) + int'(cols_eff)) > MAX_SPAN;

	assign scan_ctrl.start   = (state_q == ST_KICK);
	assign scan_ctrl.collect = collect_q;
	assign scan_ctrl.clear   = item_accept && (kind == KIND_LOAD) && row_in_range
		&& (row_index == '0);

	// original rows hold no reset value
	always_ff @(posedge clk) begin
		if (item_accept && (kind == KIND_LOAD) && row_in_range) begin
			orig_q[row_sel] <= load_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			span_q             <= '0;
			lat_q              <= '0;
			rc_q               <= '0;
			collect_q          <= 1'b0;
			verdict_sel_q      <= VERDICT_ANALYSED;
			out_valid_q        <= 1'b0;
			verdict_q          <= VERDICT_ANALYSED;
			forbidden_mask_q   <= '0;
			permissible_mask_q <= '0;
			span_out_q         <= '0;
			collision_vector_q <= '0;
			vector_length_q    <= '0;
			for (int r = 0; r < MAX_ROWS; r++) begin
				merged_q[r] <= '0;
			end
		end else begin
			if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_accept) begin
						if (kind == KIND_LOAD) begin
							if (row_in_range) begin
								// row zero starts a fresh table
								for (int r = 0; r < MAX_ROWS; r++) begin
									if (r == int'(row_sel)) begin
										merged_q[r] <= MW'(load_bits);
									end else if (row_index == '0) begin
										merged_q[r] <= '0;
									end
								end
								if (row_last) begin
									span_q        <= cols_eff;
									verdict_sel_q <= VERDICT_ANALYSED;
									collect_q     <= 1'b1;
									state_q       <= ST_KICK;
								end
							end
						end else if (lat_forbidden) begin
							verdict_sel_q <= VERDICT_FORBIDDEN;
							collect_q     <= 1'b0;
							state_q       <= ST_KICK;
						end else if (lat_over) begin
							verdict_sel_q <= VERDICT_OVER_SPAN;
							collect_q     <= 1'b0;
							state_q       <= ST_KICK;
						end else begin
							verdict_sel_q <= VERDICT_ACCEPTED;
							span_q        <= latency + cols_eff;
							lat_q         <= latency;
							rc_q          <= '0;
							collect_q     <= 1'b1;
							state_q       <= ST_MERGE;
						end
					end
				end
				ST_MERGE: begin
					merged_q[rc_q] <= merged_q[rc_q] | merge_row;
					if (merge_last) begin
						state_q <= ST_KICK;
					end else begin
						rc_q <= rc_q + IW'(1);
					end
				end
				ST_KICK: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_done) begin
						out_valid_q        <= 1'b1;
						verdict_q          <= verdict_sel_q;
						forbidden_mask_q   <= forb64;
						permissible_mask_q <= low_ones(span_q) & ~forb64;
						span_out_q         <= span_q;
						collision_vector_q <= forb64 & low_ones(scan_len);
						vector_length_q    <= scan_len;
						state_q            <= ST_IDLE;
					end
				end
			endcase
		end
	end

	rtcv_scan #(
		.ROWS  (MAX_ROWS),
		.WIDTH (MW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (scan_ctrl),
		.rows_in   (merged_q),
		.row_en    (row_en),
		.span      (span_q),
		.done      (scan_done),
		.forbidden (scan_forb),
		.length    (scan_len)
	);

	assign result_valid     = out_valid_q;
	assign verdict          = verdict_q;
	assign forbidden_mask   = forbidden_mask_q;
	assign permissible_mask = permissible_mask_q;
	assign span             = span_out_q;
	assign collision_vector = collision_vector_q;
	assign vector_length    = vector_length_q;

endmodule

>>> tb/tb_reservation_table_collision_vector.sv
// self-checking testbench for reservation_table_collision_vector: loads tables, proposes
// latencies and checks every result against an in-bench scheduler model
// depends on rtcv_pkg and the reservation_table_collision_vector rtl
module tb_reservation_table_collision_vector;
	import rtcv_pkg::*;

	localparam int TABLE_ROWS     = 8;
	localparam int TABLE_COLS     = 32;
	localparam int TABLE_SPAN_CAP = 64;
	localparam int ITEM_TARGET    = 1800;
	localparam int SETTLE_CYCLES  = 100;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [MASK_W-1:0]    forbidden;
		logic [MASK_W-1:0]    permissible;
		logic [SPAN_W-1:0]    span;
		logic [MASK_W-1:0]    collision;
		logic [SPAN_W-1:0]    vec_len;
	} sched_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  item_valid;
	logic                  item_ready;
	logic                  kind;
	logic [ROW_IDX_W-1:0]  row_index;
	logic [ROW_BITS_W-1:0] row_bits;
	logic [SPAN_W-1:0]     latency;
	logic                  result_valid;
	logic                  result_ready;
	logic [VERDICT_W-1:0]  verdict;
	logic [MASK_W-1:0]     forbidden_mask;
	logic [MASK_W-1:0]     permissible_mask;
	logic [SPAN_W-1:0]     span;
	logic [MASK_W-1:0]     collision_vector;
	logic [SPAN_W-1:0]     vector_length;

	// scheduler model state
	logic [ROWCNT_W-1:0]   rows_cfg = 4'd1;
	logic [COLCNT_W-1:0]   cols_cfg = 6'd1;
	logic [ROW_BITS_W-1:0] orig_rows [TABLE_ROWS];
	logic [MASK_W-1:0]     merged_rows [TABLE_ROWS];
	logic [MASK_W-1:0]     forbidden_lat = '0;
	logic [SPAN_W-1:0]     cur_span = '0;
	logic [TABLE_ROWS-1:0] row_loaded = '0;

	sched_result_t pending_results[$];
	int            mismatches = 0;
	int            items_sent = 0;
	int            stalled_cycles = 0;
	bit            idle_on = 1'b1;
	bit            hold_req = 1'b0;

	reservation_table_collision_vector u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.item_valid       (item_valid),
		.item_ready       (item_ready),
		.kind             (kind),
		.row_index        (row_index),
		.row_bits         (row_bits),
		.latency          (latency),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.verdict          (verdict),
		.forbidden_mask   (forbidden_mask),
		.permissible_mask (permissible_mask),
		.span             (span),
		.collision_vector (collision_vector),
		.vector_length    (vector_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [MASK_W-1:0] ones_below(input int n);
		return (n >= MASK_W) ? {MASK_W{1'b1}} : ((64'd1 << n) - 64'd1);
	endfunction

	function automatic int rows_used();
		if (rows_cfg == 0)
			return 1;
		return (rows_cfg > TABLE_ROWS) ? TABLE_ROWS : int'(rows_cfg);
	endfunction

	function automatic int cols_used();
		if (cols_cfg == 0)
			return 1;
		return (cols_cfg > TABLE_COLS) ? TABLE_COLS : int'(cols_cfg);
	endfunction

	function automatic bit latency_is_forbidden(input logic [SPAN_W-1:0] lat);
		if (lat == 0 || lat > TABLE_SPAN_CAP)
			return 1'b0;
		return forbidden_lat[lat - 1];
	endfunction

	function automatic bit over_capacity(input logic [SPAN_W-1:0] lat);
		return (int'(lat) + cols_used()) > TABLE_SPAN_CAP;
	endfunction

	function automatic bit table_ready();
		for (int r = 0; r < rows_used(); r++)
			if (!row_loaded[r])
				return 1'b0;
		return 1'b1;
	endfunction

	// every distance between two marks of one merged row is a forbidden latency
	function automatic void gather_distances();
		logic [MASK_W-1:0] v;
		for (int r = 0; r < rows_used(); r++) begin
			v = merged_rows[r];
			for (int d = 1; d < MASK_W; d++)
				if ((v & (v >> d)) != '0)
					forbidden_lat[d-1] = 1'b1;
		end
	endfunction

	function automatic sched_result_t analysis(input logic [VERDICT_W-1:0] v);
		sched_result_t res;
		logic [MASK_W-1:0] perm;
		int len;
		perm = ones_below(int'(cur_span)) & ~forbidden_lat;
		len = 0;
		for (int d = MASK_W; d >= 1; d--)
			if (len == 0 && perm[d-1])
				len = d;
		res.verdict = v;
		res.forbidden = forbidden_lat;
		res.permissible = perm;
		res.span = cur_span;
		res.collision = forbidden_lat & ones_below(len);
		res.vec_len = SPAN_W'(len);
		return res;
	endfunction

	function automatic bit schedule_step(input logic k, input logic [ROW_IDX_W-1:0] row,
			input logic [ROW_BITS_W-1:0] bits, input logic [SPAN_W-1:0] lat,
			output sched_result_t res);
		int rows;
		int cols;
		rows = rows_used();
		cols = cols_used();
		res = '0;
		if (k == KIND_LOAD) begin
			if (int'(row) >= rows)
				return 1'b0;
			if (row == 0) begin
				for (int r = 0; r < TABLE_ROWS; r++)
					merged_rows[r] = '0;
				forbidden_lat = '0;
			end
			orig_rows[row] = bits & ROW_BITS_W'(ones_below(cols));
			merged_rows[row] = {32'b0, orig_rows[row]};
			row_loaded[row] = 1'b1;
			if (int'(row) != rows - 1)
				return 1'b0;
			gather_distances();
			cur_span = SPAN_W'(cols);
			res = analysis(VERDICT_ANALYSED);
			return 1'b1;
		end
		// forbidden check takes precedence over the span limit
		if (latency_is_forbidden(lat)) begin
			res = analysis(VERDICT_FORBIDDEN);
			return 1'b1;
		end
		if (over_capacity(lat)) begin
			res = analysis(VERDICT_OVER_SPAN);
			return 1'b1;
		end
		for (int r = 0; r < rows; r++)
			merged_rows[r] = merged_rows[r] | (({32'b0, orig_rows[r]} & ones_below(cols)) << lat);
		gather_distances();
		cur_span = SPAN_W'(cols + int'(lat));
		res = analysis(VERDICT_ACCEPTED);
		return 1'b1;
	endfunction

	function automatic logic [ROW_BITS_W-1:0] pick_row_bits();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom & $urandom & $urandom;
			2: return (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
			3: return $urandom & $urandom & $urandom & $urandom & $urandom;
			default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	// mostly latencies that will be taken, some forbidden ones and some anything
	function automatic logic [SPAN_W-1:0] pick_latency();
		int open_lat[$];
		int shut_lat[$];
		int sel;
		for (int d = 0; d <= TABLE_SPAN_CAP; d++) begin
			if (latency_is_forbidden(SPAN_W'(d)))
				shut_lat.push_back(d);
			else if (!over_capacity(SPAN_W'(d)))
				open_lat.push_back(d);
		end
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return SPAN_W'(open_lat[$urandom_range(0, open_lat.size() - 1)]);
		if (sel < 8 && shut_lat.size() != 0)
			return SPAN_W'(shut_lat[$urandom_range(0, shut_lat.size() - 1)]);
		return SPAN_W'($urandom_range(0, 127));
	endfunction

	function automatic int pick_count(input int cap, input int top);
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 1;
			2: return cap;
			3: return top;
			default: return $urandom_range(0, top);
		endcase
	endfunction

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ROW_COUNT:    rows_cfg = value[ROWCNT_W-1:0];
			REG_COLUMN_COUNT: cols_cfg = value[COLCNT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input int rows, input int cols);
		logic [APB_DATA_W-1:0] junk;
		junk = $urandom_range(0, 3) == 0 ? ($urandom << 6) : '0;
		write_reg(REG_ROW_COUNT, junk | APB_DATA_W'(rows));
		write_reg(REG_COLUMN_COUNT, junk | APB_DATA_W'(cols));
	endtask

	task automatic push_item(input logic k, input logic [ROW_IDX_W-1:0] row,
			input logic [ROW_BITS_W-1:0] bits, input logic [SPAN_W-1:0] lat);
		sched_result_t res;
		// a latency that merges needs every used row of the original table written
		if (k == KIND_LATENCY && !latency_is_forbidden(lat) && !over_capacity(lat)
				&& !table_ready()) begin
			k = KIND_LOAD;
			for (int r = rows_used() - 1; r >= 0; r--)
				if (!row_loaded[r])
					row = ROW_IDX_W'(r);
		end
		if (k == KIND_LATENCY || int'(row) < rows_used())
			items_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= k;
		row_index <= row;
		row_bits <= bits;
		latency <= lat;
		do @(posedge clk); while (!item_ready);
		if (schedule_step(k, row, bits, lat, res))
			pending_results.push_back(res);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_table_sequence();
		for (int r = 0; r < rows_used(); r++)
			push_item(KIND_LOAD, ROW_IDX_W'(r), pick_row_bits(), SPAN_W'($urandom_range(0, 127)));
		repeat ($urandom_range(1, 8))
			push_item(KIND_LATENCY, ROW_IDX_W'($urandom_range(0, 7)), $urandom, pick_latency());
	endtask

	task automatic push_noise();
		push_item(logic'($urandom_range(0, 1)), ROW_IDX_W'($urandom_range(0, 7)),
			pick_row_bits(), SPAN_W'($urandom_range(0, 127)));
	endtask

	task automatic test_directed();
		// nothing loaded yet: span zero, only over-span latencies are safe
		push_item(KIND_LATENCY, 3'd0, 32'h0, 7'd64);
		push_item(KIND_LATENCY, 3'd7, 32'hFFFF_FFFF, 7'd127);
		drain_results();
		write_reg(REG_ROW_COUNT, 32'hFFFF_FFF3);
		write_reg(REG_COLUMN_COUNT, 32'd8);
		push_item(KIND_LOAD, 3'd1, 32'h0000_0042, 7'd0);
		push_item(KIND_LOAD, 3'd0, 32'h0000_0081, 7'd0);
		push_item(KIND_LOAD, 3'd5, 32'h1234_5678, 7'd0);
		push_item(KIND_LOAD, 3'd1, 32'h0000_0005, 7'd0);
		// bits above the column count get dropped
		push_item(KIND_LOAD, 3'd2, 32'hFFFF_FFFF, 7'd0);
		push_item(KIND_LATENCY, 3'd0, 32'h0, 7'd3);
		push_item(KIND_LATENCY, 3'd0, 32'h0, 7'd57);
		push_item(KIND_LATENCY, 3'd0, 32'h0, 7'd0);
		push_item(KIND_LATENCY, 3'd0, 32'h0, 7'd56);
		push_item(KIND_LATENCY, 3'd0, 32'h0, 7'd64);
		drain_results();
		// forbidden distances cover the whole span after latency zero
		write_reg(REG_ROW_COUNT, 32'd1);
		write_reg(REG_COLUMN_COUNT, 32'd2);
		push_item(KIND_LOAD, 3'd0, 32'h0000_0003, 7'd0);
		push_item(KIND_LATENCY, 3'd0, 32'h0, 7'd2);
		push_item(KIND_LATENCY, 3'd0, 32'h0, 7'd0);
		drain_results();
		write_reg(REG_ROW_COUNT, 32'd15);
		write_reg(REG_COLUMN_COUNT, 32'd63);
		push_item(KIND_LOAD, 3'd0, 32'h8000_0001, 7'd0);
		for (int r = 1; r < TABLE_ROWS - 1; r++)
			push_item(KIND_LOAD, ROW_IDX_W'(r), 32'h0, 7'd0);
		push_item(KIND_LOAD, 3'd7, 32'hAAAA_AAAA, 7'd0);
		push_item(KIND_LATENCY, 3'd0, 32'h0, 7'd1);
		drain_results();
	endtask

	task automatic test_backpressure();
		configure(2, 16);
		hold_req <= 1'b1;
		repeat (3) run_table_sequence();
		drain_results();
	endtask

	task automatic test_random_phases();
		int phase;
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			drain_results();
			idle_on = (phase % 4 != 3) && (items_sent < ITEM_TARGET - 200);
			configure(pick_count(TABLE_ROWS, 15), pick_count(TABLE_COLS, 63));
			repeat ($urandom_range(6, 14)) begin
				if ($urandom_range(0, 5) == 0)
					repeat ($urandom_range(1, 4)) push_noise();
				else
					run_table_sequence();
			end
			phase++;
		end
		drain_results();
	endtask

	// result receiver, with random stalls and one long hold-off on request
	initial begin
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				result_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		sched_result_t got;
		sched_result_t want;
		if (arst_n && result_valid && result_ready) begin
			got = {verdict, forbidden_mask, permissible_mask, span, collision_vector,
				vector_length};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item on result port: verdict %0d span %0d", verdict, span);
			end else begin
				want = pending_results.pop_front();
				if (got.verdict !== want.verdict || got.forbidden !== want.forbidden
						|| got.permissible !== want.permissible || got.span !== want.span
						|| got.collision !== want.collision || got.vec_len !== want.vec_len) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result mismatch (expected/actual): verdict %0d/%0d",
							want.verdict, got.verdict);
						$display("  forbidden %h/%h permissible %h/%h",
							want.forbidden, got.forbidden, want.permissible, got.permissible);
						$display("  span %0d/%0d vector %h/%h length %0d/%0d",
							want.span, got.span, want.collision, got.collision,
							want.vec_len, got.vec_len);
					end
				end
			end
		end
		if ((item_valid && item_ready) || (result_valid && result_ready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_valid <= 1'b0;
		kind <= KIND_LOAD;
		row_index <= '0;
		row_bits <= '0;
		latency <= '0;
		for (int r = 0; r < TABLE_ROWS; r++) begin
			orig_rows[r] = '0;
			merged_rows[r] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_phases();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
